// File: sv/cfqs_pkg.sv
// ---------------------------------------------------------------------------
// cfqs_pkg
// Shared widths, codes and configuration type of the credit fair queue
// scheduler.
// ---------------------------------------------------------------------------
package cfqs_pkg;

    localparam int SIZE_W      = 11;
    localparam int TAG_W       = 3;
    localparam int LIMIT_W     = 6;
    localparam int GAIN_W      = 16;
    localparam int CREDIT_W    = 32;
    localparam int DROP_W      = 16;
    localparam int OUT_Q_W     = 3;
    localparam int OUT_FLOW_W  = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int OUT_FIELD_W = OUT_Q_W + CREDIT_W + OUT_Q_W + SIZE_W + OUT_FLOW_W
                               + TAG_W + CREDIT_W + DROP_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
    localparam int OUT_TUSER_W = STATUS_W + 1;

    localparam logic [STATUS_W-1:0] ENQ_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ENQ_QUEUED  = 2'd1;
    localparam logic [STATUS_W-1:0] ENQ_DROPPED = 2'd2;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_DRAIN   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_COST = 2'd2;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 6'd20;
    localparam logic [GAIN_W-1:0]   GAIN_RESET  = 16'd66;
    localparam logic [CREDIT_W-1:0] COST_RESET  = 32'd65536;

    typedef struct packed {
        logic [LIMIT_W-1:0]  queue_limit;
        logic [GAIN_W-1:0]   base_gain;
        logic [CREDIT_W-1:0] service_cost;
    } t_cfg;

endpackage

// File: sv/cfqs_front.sv
// ---------------------------------------------------------------------------
// cfqs_front
// Accepts input items and steers each one to its FIFO index (flow modulo
// the number of queues) before handing it to the item queue.
// ---------------------------------------------------------------------------
module cfqs_front import cfqs_pkg::*; #(
    parameter int NUM_QUEUES = 5,
    parameter int FLOW_BITS  = 8
) (
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  logic                  i_func,
    input  logic [SIZE_W-1:0]     i_size,
    input  logic [TAG_W-1:0]      i_tag,
    input  logic [FLOW_BITS-1:0]  i_flow,
    input  logic                  i_full,
    output logic                  o_push,
    // func, queue, size, tag, flow from the lowest bit up
    output logic [1+$clog2(NUM_QUEUES)+SIZE_W+TAG_W+FLOW_BITS-1:0] o_item
);

    localparam int QW      = $clog2(NUM_QUEUES);
    localparam int RES_MAX = FLOW_BITS * (NUM_QUEUES - 1);
    localparam int SW      = $clog2(RES_MAX + 1);

    logic [SW-1:0] res_term [FLOW_BITS];
    logic [QW-1:0] mod_tab  [RES_MAX+1];
    logic [SW-1:0] res_sum;
    logic [QW-1:0] fifo_sel;

    // residue of each flow bit weight
    for (genvar k = 0; k < FLOW_BITS; k++) begin : g_res
        localparam int unsigned RES = (2 ** k) % NUM_QUEUES;
        assign res_term[k] = i_flow[k] ? SW'(RES) : '0;
    end

    // final reduction table
    for (genvar v = 0; v <= RES_MAX; v++) begin : g_mod
        assign mod_tab[v] = QW'(v % NUM_QUEUES);
    end

    always_comb begin
        res_sum = '0;
        for (int k = 0; k < FLOW_BITS; k++) begin
            res_sum = res_sum + res_term[k];
        end
    end

    assign fifo_sel  = mod_tab[res_sum];
    assign o_s_ready = !i_full;
    assign o_push    = i_s_valid && !i_full;
    assign o_item    = {i_flow, i_tag, i_size, fifo_sel, i_func};

endmodule

// File: sv/cfqs_fifo.sv
// ---------------------------------------------------------------------------
// cfqs_fifo
// Two-entry queue of classified items between the front and the back.
// ---------------------------------------------------------------------------
module cfqs_fifo import cfqs_pkg::*; #(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_item,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_item,
    input  logic         i_pop
);

    logic [W-1:0] r_slot [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rd];

endmodule

// File: sv/cfqs_back.sv
// ---------------------------------------------------------------------------
// cfqs_back
// Carries out one item: credit update and enqueue for an arrival, winner selection and
// dequeue from the packet memory, then the result register.
// ---------------------------------------------------------------------------
module cfqs_back import cfqs_pkg::*; #(
    parameter int NUM_QUEUES  = 5,
    parameter int QUEUE_DEPTH = 32,
    parameter int FLOW_BITS   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    input  logic [1+$clog2(NUM_QUEUES)+SIZE_W+TAG_W+FLOW_BITS-1:0] i_item,
    output logic                   o_pop,
    output logic                   o_m_valid,
    input  logic                   i_m_ready,
    output logic [OUT_TDATA_W-1:0] o_m_data,
    output logic [OUT_TUSER_W-1:0] o_m_user
);

    localparam int QW        = $clog2(NUM_QUEUES);
    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int LW        = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int AW        = QW + PW;
    localparam int MEM_DEPTH = NUM_QUEUES << PW;
    localparam int ENT_W     = SIZE_W + TAG_W + FLOW_BITS;
    localparam int SIZE_LO   = 1 + QW;
    localparam int PROD_W    = GAIN_W + QW + 1;

    typedef enum logic [1:0] {S_IDLE, S_SEL, S_OUT} t_state;

    t_state              r_state;
    logic [CW-1:0]       r_fill   [NUM_QUEUES];
    logic [PW-1:0]       r_head   [NUM_QUEUES];
    logic [PW-1:0]       r_tail   [NUM_QUEUES];
    logic [CREDIT_W-1:0] r_credit [NUM_QUEUES];
    logic [DROP_W-1:0]   r_drop;
    logic [ENT_W-1:0]    r_mem    [MEM_DEPTH];
    logic [ENT_W-1:0]    r_rd_data;

    logic                r_func;
    logic [QW-1:0]       r_q;
    logic [STATUS_W-1:0] r_enq_status;
    logic [CREDIT_W-1:0] r_enq_credit;
    logic                r_deq_valid;
    logic [QW-1:0]       r_deq_q;
    logic [CREDIT_W-1:0] r_deq_credit;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user;

    logic                it_func;
    logic [QW-1:0]       it_q;
    logic [ENT_W-1:0]    it_entry;
    logic [QW:0]         weight;
    logic [PROD_W-1:0]   gain_prod;
    logic [CREDIT_W:0]   credit_sum;
    logic [CREDIT_W-1:0] add_credit;
    logic [LW-1:0]       lim;
    logic                has_room;
    logic [PW-1:0]       tail_next;
    logic                mem_we;

    logic                sel_found;
    logic [QW-1:0]       sel_idx;
    logic [CREDIT_W-1:0] best_credit;
    logic [CREDIT_W-1:0] sel_credit;
    logic [CREDIT_W-1:0] sub_credit;
    logic [PW-1:0]       head_next;
    logic                mem_re;
    logic                out_load;

    logic [OUT_Q_W-1:0]    eq_q;
    logic [OUT_Q_W-1:0]    dq_q;
    logic [SIZE_W-1:0]     dq_size;
    logic [TAG_W-1:0]      dq_tag;
    logic [OUT_FLOW_W-1:0] dq_flow;
    logic [CREDIT_W-1:0]   dq_credit;

    function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
        logic [PW:0] n;
        n = {1'b0, p} + (PW+1)'(1);
        return (n >= (PW+1)'(QUEUE_DEPTH)) ? '0 : n[PW-1:0];
    endfunction

    // enqueue side
    always_comb begin
        it_func    = i_item[0];
        it_q       = i_item[1 +: QW];
        it_entry   = i_item[SIZE_LO +: ENT_W];
        weight     = {1'b0, it_q} + (QW+1)'(1);
        gain_prod  = PROD_W'(weight) * PROD_W'(i_cfg.base_gain);
        credit_sum = {1'b0, r_credit[it_q]} + (CREDIT_W+1)'(gain_prod);
        add_credit = credit_sum[CREDIT_W] ? '1 : credit_sum[CREDIT_W-1:0];
        lim        = (LW'(i_cfg.queue_limit) > LW'(QUEUE_DEPTH)) ?
                     LW'(QUEUE_DEPTH) : LW'(i_cfg.queue_limit);
        has_room   = LW'(r_fill[it_q]) < lim;
        tail_next  = wrap_next(r_tail[it_q]);
    end

    assign o_pop  = (r_state == S_IDLE) && i_valid;
    assign mem_we = o_pop && (it_func == FUNC_ARRIVAL) && has_room;

    // winner selection
    always_comb begin
        sel_found   = 1'b0;
        sel_idx     = '0;
        best_credit = '0;
        for (int i = 0; i < NUM_QUEUES; i++) begin
            if (r_fill[i] != '0) begin
                if (r_func == FUNC_DRAIN) begin
                    if (!sel_found) begin
                        sel_found = 1'b1;
                        sel_idx   = QW'(i);
                    end
                end else if (!sel_found || (r_credit[i] > best_credit)) begin
                    sel_found   = 1'b1;
                    sel_idx     = QW'(i);
                    best_credit = r_credit[i];
                end
            end
        end
        sel_credit = r_credit[sel_idx];
        sub_credit = (sel_credit > i_cfg.service_cost) ?
                     sel_credit - i_cfg.service_cost : '0;
        head_next  = wrap_next(r_head[sel_idx]);
    end

    assign mem_re   = (r_state == S_SEL) && sel_found;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_ready);

    // result packing
    always_comb begin
        eq_q      = (r_enq_status == ENQ_NONE) ? '0 : OUT_Q_W'(r_q);
        dq_q      = r_deq_valid ? OUT_Q_W'(r_deq_q) : '0;
        dq_size   = r_deq_valid ? r_rd_data[0 +: SIZE_W] : '0;
        dq_tag    = r_deq_valid ? r_rd_data[SIZE_W +: TAG_W] : '0;
        dq_flow   = r_deq_valid ? OUT_FLOW_W'(r_rd_data[SIZE_W+TAG_W +: FLOW_BITS]) : '0;
        dq_credit = r_deq_valid ? r_deq_credit : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_drop      <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_fill[i]   <= '0;
                r_head[i]   <= '0;
                r_tail[i]   <= '0;
                r_credit[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_m_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= it_func;
                        r_q     <= it_q;
                        r_state <= S_SEL;
                        if (it_func == FUNC_ARRIVAL) begin
                            r_credit[it_q] <= add_credit;
                            r_enq_credit   <= add_credit;
                            if (has_room) begin
                                r_tail[it_q] <= tail_next;
                                r_fill[it_q] <= r_fill[it_q] + CW'(1);
                                r_enq_status <= ENQ_QUEUED;
                            end else begin
                                r_enq_status <= ENQ_DROPPED;
                                if (r_drop != '1) begin
                                    r_drop <= r_drop + DROP_W'(1);
                                end
                            end
                        end else begin
                            r_enq_status <= ENQ_NONE;
                            r_enq_credit <= '0;
                        end
                    end
                end
                S_SEL: begin
                    r_deq_valid  <= sel_found;
                    r_deq_q      <= sel_idx;
                    r_deq_credit <= sub_credit;
                    if (sel_found) begin
                        r_head[sel_idx]   <= head_next;
                        r_fill[sel_idx]   <= r_fill[sel_idx] - CW'(1);
                        r_credit[sel_idx] <= sub_credit;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {{OUT_PAD_W{1'b0}}, r_drop, dq_credit, dq_tag,
                                        dq_flow, dq_size, dq_q, r_enq_credit, eq_q};
                        r_out_user  <= {r_deq_valid, r_enq_status};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // packet memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'({it_q, r_tail[it_q]})] <= it_entry;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[AW'({sel_idx, r_head[sel_idx]})];
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_user  = r_out_user;

endmodule

// File: sv/credit_fair_queue_scheduler.sv
// ---------------------------------------------------------------------------
// credit_fair_queue_scheduler
// Credit based fair queuing over weighted bounded FIFOs.
// ---------------------------------------------------------------------------
// Items enter on s_axis: tuser is func (0 arrival, 1 drain), tdata carries
// pkt_size, pkt_weight and flow_id. Each item gives exactly one result on
// m_axis: tuser carries enq_status and deq_valid, tdata the enqueue and
// dequeue fields and the drop count.
// Registers are written on the cfg channel (index 0 queue_limit, 1 base_gain,
// 2 service_cost), which is always ready; write them only while idle.
// An accepted item waits in the queue until the back end is idle; the back
// end works on one item at a time: enqueue and credit update, winner
// selection with the packet memory read, and the result register load.
// A two-entry queue sits between the classifier and the back end, so up to
// two more items are taken while one is in work.
// Reset clears fill counts, pointers, credits and the drop count at once
// and restores the register defaults; the packet memory is not cleared.
// When m_axis stalls the result holds in its register, the back end waits
// at the load step and s_axis backs up once the queue fills.
// ---------------------------------------------------------------------------
module credit_fair_queue_scheduler import cfqs_pkg::*; #(
    parameter int NUM_QUEUES  = 5,
    parameter int QUEUE_DEPTH = 32,
    parameter int FLOW_BITS   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pkt_size, pkt_weight, flow_id, zero pad
    input  logic [((SIZE_W+TAG_W+FLOW_BITS+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // enq_queue, enq_credit, deq_queue, deq_size, deq_flow, deq_weight_tag,
    // deq_credit, drop_total, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // enq_status, deq_valid
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int QW     = $clog2(NUM_QUEUES);
    localparam int ITEM_W = 1 + QW + SIZE_W + TAG_W + FLOW_BITS;

    t_cfg              r_cfg;
    logic              push;
    logic              full;
    logic [ITEM_W-1:0] front_item;
    logic              q_valid;
    logic [ITEM_W-1:0] q_item;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.queue_limit  <= LIMIT_RESET;
            r_cfg.base_gain    <= GAIN_RESET;
            r_cfg.service_cost <= COST_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_QUEUE_LIMIT:  r_cfg.queue_limit  <= i_cfg_data[LIMIT_W-1:0];
                REG_BASE_GAIN:    r_cfg.base_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_SERVICE_COST: r_cfg.service_cost <= i_cfg_data[CREDIT_W-1:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    cfqs_front #(
        .NUM_QUEUES (NUM_QUEUES),
        .FLOW_BITS  (FLOW_BITS)
    ) u_front (
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_func    (s_axis_tuser),
        .i_size    (s_axis_tdata[0 +: SIZE_W]),
        .i_tag     (s_axis_tdata[SIZE_W +: TAG_W]),
        .i_flow    (s_axis_tdata[SIZE_W+TAG_W +: FLOW_BITS]),
        .i_full    (full),
        .o_push    (push),
        .o_item    (front_item)
    );

    cfqs_fifo #(
        .W (ITEM_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    cfqs_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FLOW_BITS   (FLOW_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata),
        .o_m_user  (m_axis_tuser)
    );

endmodule

// File: bench/credit_fair_queue_scheduler_tb.sv
// ---------------------------------------------------------------------------
// credit_fair_queue_scheduler_tb
// Self-checking bench for the credit fair queue scheduler. A credit ledger
// class tracks fill counts, pointers, credits and drops, and works out the
// grant that each accepted item must produce. Both stream sides idle at
// random. Phases with different register settings cover the zero limit,
// a limit above the FIFO depth, the cost extremes, and a drop run that
// piles onto the heaviest FIFO.
// ---------------------------------------------------------------------------
module credit_fair_queue_scheduler_tb;
    import cfqs_pkg::*;

    localparam int NQ         = 5;
    localparam int DEPTH      = 32;
    localparam int FLOW_W     = 8;
    localparam int IN_TDATA_W = ((SIZE_W + TAG_W + FLOW_W + 7) / 8) * 8;

    typedef struct packed {
        logic [OUT_PAD_W-1:0]  pad;
        logic [DROP_W-1:0]     drop_total;
        logic [CREDIT_W-1:0]   deq_credit;
        logic [TAG_W-1:0]      deq_tag;
        logic [OUT_FLOW_W-1:0] deq_flow;
        logic [SIZE_W-1:0]     deq_size;
        logic [OUT_Q_W-1:0]    deq_queue;
        logic [CREDIT_W-1:0]   enq_credit;
        logic [OUT_Q_W-1:0]    enq_queue;
    } t_result_word;

    typedef struct packed {
        logic                deq_valid;
        logic [STATUS_W-1:0] enq_status;
        t_result_word        word;
    } t_grant;

    class t_credit_ledger;
        int                  fill [NQ];
        int                  head [NQ];
        int                  tail [NQ];
        logic [CREDIT_W-1:0] credit [NQ];
        logic [21:0]         slots [NQ*DEPTH];
        logic [DROP_W-1:0]   drops;
        logic [LIMIT_W-1:0]  limit;
        logic [GAIN_W-1:0]   gain;
        logic [CREDIT_W-1:0] cost;
        t_grant              grants_due [$];
        int                  errors;

        function new();
            for (int i = 0; i < NQ; i++) begin
                fill[i]   = 0;
                head[i]   = 0;
                tail[i]   = 0;
                credit[i] = '0;
            end
            drops  = '0;
            limit  = LIMIT_RESET;
            gain   = GAIN_RESET;
            cost   = COST_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_QUEUE_LIMIT:  limit = data[LIMIT_W-1:0];
                REG_BASE_GAIN:    gain  = data[GAIN_W-1:0];
                REG_SERVICE_COST: cost  = data[CREDIT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return grants_due.size();
        endfunction

        function void admit_packet_event(logic func, logic [SIZE_W-1:0] size,
                                         logic [TAG_W-1:0] tag, logic [FLOW_W-1:0] flow);
            t_grant              g;
            int                  q;
            int                  sel;
            int                  lim;
            logic [CREDIT_W-1:0] inc;
            logic [CREDIT_W:0]   sum;
            logic [21:0]         slot;
            g   = '0;
            sel = -1;
            if (func == FUNC_ARRIVAL) begin
                q   = flow % NQ;
                inc = (q + 1) * gain;
                sum = credit[q] + inc;
                credit[q] = sum[CREDIT_W] ? '1 : sum[CREDIT_W-1:0];
                lim = (limit > DEPTH) ? DEPTH : limit;
                g.word.enq_queue  = OUT_Q_W'(q);
                g.word.enq_credit = credit[q];
                if (fill[q] < lim) begin
                    slots[q*DEPTH + tail[q]] = {flow, tag, size};
                    tail[q] = (tail[q] + 1) % DEPTH;
                    fill[q]++;
                    g.enq_status = ENQ_QUEUED;
                end else begin
                    g.enq_status = ENQ_DROPPED;
                    if (drops != '1) drops++;
                end
                for (int i = 0; i < NQ; i++)
                    if (fill[i] > 0 && (sel < 0 || credit[i] > credit[sel])) sel = i;
            end else begin
                g.enq_status = ENQ_NONE;
                for (int i = 0; i < NQ; i++)
                    if (fill[i] > 0 && sel < 0) sel = i;
            end
            if (sel >= 0) begin
                slot = slots[sel*DEPTH + head[sel]];
                head[sel] = (head[sel] + 1) % DEPTH;
                fill[sel]--;
                credit[sel] = (credit[sel] > cost) ? credit[sel] - cost : '0;
                g.deq_valid        = 1'b1;
                g.word.deq_queue   = OUT_Q_W'(sel);
                g.word.deq_size    = slot[10:0];
                g.word.deq_tag     = slot[13:11];
                g.word.deq_flow    = slot[21:14];
                g.word.deq_credit  = credit[sel];
            end
            g.word.drop_total = drops;
            grants_due.push_back(g);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            end
        endfunction

        function void match_grant(logic [OUT_TUSER_W-1:0] user, logic [OUT_TDATA_W-1:0] data);
            t_grant want;
            t_grant got;
            got.deq_valid  = user[STATUS_W];
            got.enq_status = user[STATUS_W-1:0];
            got.word       = data;
            if (grants_due.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none got %h %h",
                         $time, user, data);
                return;
            end
            want = grants_due.pop_front();
            check_field("enq_status", want.enq_status, got.enq_status);
            check_field("enq_queue", want.word.enq_queue, got.word.enq_queue);
            check_field("enq_credit", want.word.enq_credit, got.word.enq_credit);
            check_field("deq_valid", want.deq_valid, got.deq_valid);
            check_field("deq_queue", want.word.deq_queue, got.word.deq_queue);
            check_field("deq_size", want.word.deq_size, got.word.deq_size);
            check_field("deq_flow", want.word.deq_flow, got.word.deq_flow);
            check_field("deq_weight_tag", want.word.deq_tag, got.word.deq_tag);
            check_field("deq_credit", want.word.deq_credit, got.word.deq_credit);
            check_field("drop_total", want.word.drop_total, got.word.drop_total);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = FUNC_ARRIVAL;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = REG_QUEUE_LIMIT;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    bit             tx_quiet = 1'b0;
    bit             rx_quiet = 1'b0;
    t_credit_ledger ledger;

    credit_fair_queue_scheduler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2400000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            ledger.match_grant(m_axis_tuser, m_axis_tdata);
        end
    end

    task automatic send_item(input logic func, input logic [SIZE_W-1:0] size,
                             input logic [TAG_W-1:0] tag, input logic [FLOW_W-1:0] flow);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= IN_TDATA_W'({flow, tag, size});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ledger.admit_packet_event(func, size, tag, flow);
    endtask

    // hold off until every grant is back and the back end is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ledger.set_reg(idx, data);
    endtask

    task automatic run_phase(input logic [31:0] lim, input logic [31:0] gain,
                             input logic [31:0] cost, input int count, input int drain_pct,
                             input int q4_items, input bit quiet);
        logic [FLOW_W-1:0] flow;
        logic              func;
        settle();
        write_reg(REG_QUEUE_LIMIT, lim);
        write_reg(REG_BASE_GAIN, gain);
        write_reg(REG_SERVICE_COST, cost);
        i_cfg_valid <= 1'b0;
        tx_quiet = quiet;
        rx_quiet = quiet;
        for (int n = 0; n < count; n++) begin
            // early items of a biased phase all land on the heaviest FIFO
            flow = (n < q4_items) ? FLOW_W'(5 * $urandom_range(0, 50) + 4)
                                  : FLOW_W'($urandom_range(0, 255));
            func = ($urandom_range(0, 99) < drain_pct) ? FUNC_DRAIN : FUNC_ARRIVAL;
            send_item(func, SIZE_W'($urandom_range(0, 2047)), TAG_W'($urandom_range(0, 7)),
                      flow);
        end
    endtask

    initial begin : stimulus
        ledger = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // drain with nothing queued, then each FIFO and the field extremes
        send_item(FUNC_DRAIN, 11'd0, 3'd0, 8'd0);
        send_item(FUNC_ARRIVAL, 11'd0, 3'd0, 8'd0);
        send_item(FUNC_ARRIVAL, 11'd2047, 3'd7, 8'd1);
        send_item(FUNC_ARRIVAL, 11'd1024, 3'd4, 8'd2);
        send_item(FUNC_ARRIVAL, 11'd1, 3'd2, 8'd3);
        send_item(FUNC_ARRIVAL, 11'd2046, 3'd5, 8'd4);
        send_item(FUNC_ARRIVAL, 11'd2047, 3'd7, 8'd255);
        send_item(FUNC_ARRIVAL, 11'd0, 3'd0, 8'd254);
        send_item(FUNC_ARRIVAL, 11'd682, 3'd1, 8'd170);
        send_item(FUNC_ARRIVAL, 11'd1365, 3'd6, 8'd85);
        send_item(FUNC_DRAIN, 11'd2047, 3'd7, 8'd255);
        send_item(FUNC_ARRIVAL, 11'd300, 3'd3, 8'd5);
        send_item(FUNC_ARRIVAL, 11'd301, 3'd3, 8'd9);
        send_item(FUNC_ARRIVAL, 11'd302, 3'd3, 8'd9);
        send_item(FUNC_DRAIN, 11'd5, 3'd2, 8'd128);

        run_phase(32'd20, 32'd66, 32'd65536, 80, 20, 0, 1'b0);
        // zero limit: every arrival dropped, credits only grow
        run_phase(32'd0, 32'd65535, 32'd0, 80, 20, 0, 1'b0);
        // limit above the FIFO depth, cost at its top
        run_phase(32'd63, $urandom, 32'hFFFF_FFFF, 80, 20, 0, 1'b0);
        run_phase(32'd1, 32'd0, $urandom, 80, 20, 0, 1'b0);
        run_phase(32'd32, $urandom, 32'($urandom_range(0, 400000)), 80, 20, 0, 1'b1);
        run_phase($urandom, $urandom, $urandom, 80, 30, 0, 1'b0);
        // drop run piled onto the heaviest FIFO
        run_phase(32'd0, 32'd65535, 32'd0, 40, 2, 30, 1'b1);
        run_phase(32'd20, 32'd1, 32'd1, 40, 20, 0, 1'b0);

        settle();
        if (ledger.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
